>>> hdl/laii_pkg.sv
`default_nettype none

package laii_pkg;

	// configuration defaults
	localparam int TABLE_ENTRIES_DEFAULT = 64;
	localparam int HEADER_BYTES_DEFAULT  = 24;
	localparam logic [31:0] LOG_CAPACITY_RESET = 32'd1048576;

	// command codes
	typedef enum logic {
		CMD_APPEND = 1'b0,
		CMD_LOOKUP = 1'b1
	} cmd_t;

	// record kinds
	typedef enum logic [2:0] {
		KIND_CREATE   = 3'd0,
		KIND_MKDIR    = 3'd1,
		KIND_DELETE   = 3'd2,
		KIND_TRUNCATE = 3'd3,
		KIND_WRITE    = 3'd4,
		KIND_SETATTR  = 3'd5,
		KIND_RENAME   = 3'd6
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_LOG_FULL   = 2'd1,
		ST_TABLE_FULL = 2'd2,
		ST_NOT_FOUND  = 2'd3
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_CHECK = 2'd1,
		S_SCAN  = 2'd2,
		S_MISS  = 2'd3
	} state_t;

	// one table entry apart from its key
	typedef struct packed {
		logic        deleted;
		logic [63:0] size;
		logic [31:0] mode;
		logic [31:0] position;
	} slot_rec_t;

	localparam int SLOT_REC_BITS = $bits(slot_rec_t);

endpackage

`default_nettype wire

>>> hdl/log_append_inode_index_core.sv
`default_nettype none

// an item passes through S_CHECK; a log-full append, and an append of a kind that leaves the
// table alone, ends there; otherwise S_SCAN compares entries until a hit or the last occupied
// entry, or S_MISS follows when the table is empty; the key search reads the inode memory
// one entry a cycle
// throughput: one item at a time; a new start is taken in the cycle done is shown
// done is a one-cycle strobe and cannot be stalled by the receiver
// reset empties the log and the table and restores the capacity to 1 MiB; no memory sweep
module log_append_inode_index_core #(
	parameter int TABLE_ENTRIES = laii_pkg::TABLE_ENTRIES_DEFAULT,
	parameter int HEADER_BYTES  = laii_pkg::HEADER_BYTES_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	// command side
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [2:0]  record_kind,
	input  logic [31:0] ino,
	input  logic [31:0] new_ino,
	input  logic [15:0] data_bytes,
	input  logic [31:0] mode_value,
	input  logic [63:0] size_value,
	input  logic [63:0] write_offset,
	input  logic [31:0] write_length,
	input  logic        size_valid,
	input  logic        mode_valid,
	// configuration
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	// result side
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] record_position,
	output logic        found,
	output logic        is_deleted,
	output logic [63:0] inode_size,
	output logic [31:0] file_mode
);

	import laii_pkg::*;

	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	state_t state_q, state_d;

	// latched item
	logic        cmd_q;
	logic [2:0]  kind_q;
	logic [31:0] key_q;
	logic [15:0] data_bytes_q;
	logic [31:0] mode_value_q;
	logic [63:0] size_value_q;
	logic [63:0] write_offset_q;
	logic [31:0] write_length_q;
	logic        size_valid_q;
	logic        mode_valid_q;

	// block state
	logic [31:0]   log_capacity_q;
	logic [31:0]   log_used_q;
	logic [CW-1:0] count_q;
	logic [AW-1:0] idx_q;
	logic [31:0]   pos_q;
	logic [63:0]   end_q;

	// result registers
	logic        done_q;
	status_t     status_q;
	logic [31:0] position_q;
	logic        found_q;
	logic        deleted_q;
	logic [63:0] size_q;
	logic [31:0] mode_q;

	// memory ports
	logic [AW-1:0]     rd_addr;
	logic [31:0]       inode_rd;
	slot_rec_t         rec_rd;
	logic [AW-1:0]     wr_addr;
	logic              inode_we;
	logic              rec_we;
	slot_rec_t         rec_wr;

	logic          accept;
	logic [32:0]   need;
	logic          log_full;
	logic          no_table;
	logic [64:0]   wr_sum;
	logic [CW-1:0] idx_next;
	logic          match;
	logic          last;
	logic          resolve;
	logic          hit;
	logic          table_full;
	slot_rec_t     base;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);

	// log reservation check and write extent end
	assign need     = {1'b0, log_used_q} + 33'(HEADER_BYTES) + 33'(data_bytes_q);
	assign log_full = need > {1'b0, log_capacity_q};
	assign no_table = (kind_q > KIND_SETATTR);
	assign wr_sum   = {1'b0, write_offset_q} + 65'(write_length_q);

	// scan compare
	assign idx_next = CW'(idx_q) + CW'(1);
	assign match    = (inode_rd == key_q);
	assign last     = (idx_next == count_q);
	assign resolve  = ((state_q == S_SCAN) && (match || last)) || (state_q == S_MISS);
	assign hit      = (state_q == S_SCAN) && match;
	assign table_full = (count_q == CW'(TABLE_ENTRIES));

	// both memories read the same entry; the read is registered, so the address leads the compare
	always_comb begin
		rd_addr = '0;
		if (state_q == S_SCAN && !last) begin
			rd_addr = idx_next[AW-1:0];
		end
	end

	// entry update, starting from a fresh entry on a miss
	always_comb begin
		base = hit ? rec_rd : '0;
		rec_wr = base;
		rec_wr.position = pos_q;
		unique case (kind_q)
			KIND_CREATE, KIND_MKDIR: begin
				rec_wr.deleted = 1'b0;
				rec_wr.size    = '0;
				rec_wr.mode    = mode_value_q;
			end
			KIND_DELETE: begin
				rec_wr.deleted = 1'b1;
			end
			KIND_TRUNCATE: begin
				rec_wr.deleted = 1'b0;
				rec_wr.size    = size_value_q;
			end
			KIND_WRITE: begin
				rec_wr.deleted = 1'b0;
				if (end_q > base.size) begin
					rec_wr.size = end_q;
				end
			end
			KIND_SETATTR: begin
				rec_wr.deleted = 1'b0;
				if (size_valid_q) begin
					rec_wr.size = size_value_q;
				end
				if (mode_valid_q) begin
					rec_wr.mode = mode_value_q;
				end
			end
			default: begin
				rec_wr = base;
			end
		endcase
	end

	// write-back of the resolved entry
	always_comb begin
		inode_we = 1'b0;
		rec_we   = 1'b0;
		wr_addr  = hit ? idx_q : count_q[AW-1:0];
		if (resolve && cmd_q == CMD_APPEND) begin
			if (hit) begin
				rec_we = 1'b1;
			end else if (!table_full) begin
				inode_we = 1'b1;
				rec_we   = 1'b1;
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (cmd_q == CMD_APPEND && (log_full || no_table)) begin
					state_d = S_IDLE;
				end else if (count_q == '0) begin
					state_d = S_MISS;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_SCAN: begin
				if (resolve) begin
					state_d = S_IDLE;
				end
			end
			S_MISS: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// item latch
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q          <= command;
			kind_q         <= record_kind;
			key_q          <= (command == CMD_APPEND &&
				(record_kind == KIND_CREATE || record_kind == KIND_MKDIR)) ? new_ino : ino;
			data_bytes_q   <= data_bytes;
			mode_value_q   <= mode_value;
			size_value_q   <= size_value;
			write_offset_q <= write_offset;
			write_length_q <= write_length;
			size_valid_q   <= size_valid;
			mode_valid_q   <= mode_valid;
		end
	end

	// scan index, record position and write end
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			idx_q <= '0;
			pos_q <= log_used_q;
			end_q <= wr_sum[64] ? '1 : wr_sum[63:0];
		end else if (state_q == S_SCAN && !resolve) begin
			idx_q <= idx_next[AW-1:0];
		end
	end

	// capacity, log fill and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			log_capacity_q <= LOG_CAPACITY_RESET;
			log_used_q     <= '0;
			count_q        <= '0;
		end else begin
			if (cfg_write) begin
				log_capacity_q <= cfg_data;
			end
			if (state_q == S_CHECK && cmd_q == CMD_APPEND && !log_full) begin
				log_used_q <= need[31:0];
			end
			if (inode_we) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == S_CHECK) && cmd_q == CMD_APPEND && (log_full || no_table))
				|| resolve;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			status_q   <= log_full ? ST_LOG_FULL : ST_OK;
			position_q <= log_full ? '0 : log_used_q;
			found_q    <= 1'b0;
			deleted_q  <= 1'b0;
			size_q     <= '0;
			mode_q     <= '0;
		end else if (resolve) begin
			found_q   <= 1'b0;
			deleted_q <= 1'b0;
			size_q    <= '0;
			mode_q    <= '0;
			if (cmd_q == CMD_LOOKUP) begin
				if (hit) begin
					status_q   <= ST_OK;
					position_q <= rec_rd.position;
					found_q    <= 1'b1;
					deleted_q  <= rec_rd.deleted;
					size_q     <= rec_rd.size;
					mode_q     <= rec_rd.mode;
				end else begin
					status_q   <= ST_NOT_FOUND;
					position_q <= '0;
				end
			end else begin
				status_q   <= (!hit && table_full) ? ST_TABLE_FULL : ST_OK;
				position_q <= pos_q;
			end
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign record_position = position_q;
	assign found           = found_q;
	assign is_deleted      = deleted_q;
	assign inode_size      = size_q;
	assign file_mode       = mode_q;

	// entry keys
	laii_ram #(
		.WIDTH(32),
		.DEPTH(TABLE_ENTRIES)
	) u_inode_ram (
		.clk   (clk),
		.we    (inode_we),
		.waddr (wr_addr),
		.wdata (key_q),
		.raddr (rd_addr),
		.rdata (inode_rd)
	);

	// entry contents
	laii_ram #(
		.WIDTH(SLOT_REC_BITS),
		.DEPTH(TABLE_ENTRIES)
	) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (wr_addr),
		.wdata (rec_wr),
		.raddr (rd_addr),
		.rdata (rec_rd)
	);

endmodule

`default_nettype wire

>>> hdl/laii_ram.sv
`default_nettype none

module laii_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// single write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> hdl/laii_checker.sv
`default_nettype none

module laii_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [31:0] record_position,
	input wire logic        found,
	input wire logic        is_deleted,
	input wire logic [63:0] inode_size,
	input wire logic [31:0] file_mode
);

	import laii_pkg::*;

	// an accepted item keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted item did not raise busy");

	// a result only follows a cycle of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without preceding work");

	// a hit is always reported with status ok
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && found |-> status == ST_OK)
		else $error("found with non-ok status");

	// a lookup miss carries nothing else
	a_miss_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_NOT_FOUND |->
			!found && !is_deleted && record_position == '0 && inode_size == '0 &&
			file_mode == '0)
		else $error("lookup miss with payload");

	// a log-full append reserves nothing
	a_log_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_LOG_FULL |-> !found && record_position == '0)
		else $error("log full with position");

endmodule

bind log_append_inode_index_core laii_checker u_laii_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.start           (start),
	.busy            (busy),
	.done            (done),
	.status          (status),
	.record_position (record_position),
	.found           (found),
	.is_deleted      (is_deleted),
	.inode_size      (inode_size),
	.file_mode       (file_mode)
);

`default_nettype wire

>>> bench/inode_index_checker.sv
`default_nettype none

module inode_index_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        command,
	input  logic [2:0]  record_kind,
	input  logic [31:0] ino,
	input  logic [31:0] new_ino,
	input  logic [15:0] data_bytes,
	input  logic [31:0] mode_value,
	input  logic [63:0] size_value,
	input  logic [63:0] write_offset,
	input  logic [31:0] write_length,
	input  logic        size_valid,
	input  logic        mode_valid,
	input  logic        cfg_write,
	input  logic [31:0] cfg_data,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [31:0] record_position,
	input  logic        found,
	input  logic        is_deleted,
	input  logic [63:0] inode_size,
	input  logic [31:0] file_mode,
	output int          fail_count,
	output int          pending,
	output logic [31:0] log_fill
);

	import laii_pkg::*;

	localparam int ENTRIES = TABLE_ENTRIES_DEFAULT;

	typedef struct {
		status_t     status;
		logic [31:0] position;
		logic        found;
		logic        deleted;
		logic [63:0] size;
		logic [31:0] mode;
	} outcome_t;

	outcome_t    outcome_q[$];
	outcome_t    oldest;
	logic [31:0] capacity_copy;
	logic [31:0] used_copy;
	logic        entry_valid[ENTRIES];
	logic [31:0] entry_inode[ENTRIES];
	logic        entry_deleted[ENTRIES];
	logic [63:0] entry_size[ENTRIES];
	logic [31:0] entry_mode[ENTRIES];
	logic [31:0] entry_position[ENTRIES];

	// lowest valid entry holding the key, or -1
	function automatic int find_entry(logic [31:0] key);
		for (int i = 0; i < ENTRIES; i++)
			if (entry_valid[i] && entry_inode[i] == key)
				return i;
		return -1;
	endfunction

	// work out the result of the item on the command ports and update the index copy
	task automatic predict_index_outcome();
		outcome_t    o;
		logic [32:0] need;
		logic [31:0] key;
		logic [64:0] write_end;
		int          slot;
		o.status   = ST_OK;
		o.position = '0;
		o.found    = 1'b0;
		o.deleted  = 1'b0;
		o.size     = '0;
		o.mode     = '0;
		if (command == CMD_LOOKUP) begin
			slot = find_entry(ino);
			if (slot < 0) begin
				o.status = ST_NOT_FOUND;
			end else begin
				o.position = entry_position[slot];
				o.found    = 1'b1;
				o.deleted  = entry_deleted[slot];
				o.size     = entry_size[slot];
				o.mode     = entry_mode[slot];
			end
		end else begin
			need = {1'b0, used_copy} + 33'(HEADER_BYTES_DEFAULT) + 33'(data_bytes);
			if (need > {1'b0, capacity_copy}) begin
				o.status = ST_LOG_FULL;
			end else begin
				o.position = used_copy;
				used_copy  = need[31:0];
				if (record_kind <= KIND_SETATTR) begin
					key = (record_kind == KIND_CREATE || record_kind == KIND_MKDIR) ?
						new_ino : ino;
					slot = find_entry(key);
					// allocate the lowest free entry on a miss
					if (slot < 0) begin
						for (int i = 0; i < ENTRIES && slot < 0; i++) begin
							if (!entry_valid[i]) begin
								slot = i;
								entry_valid[i]   = 1'b1;
								entry_inode[i]   = key;
								entry_deleted[i] = 1'b0;
								entry_size[i]    = '0;
								entry_mode[i]    = '0;
							end
						end
					end
					if (slot < 0) begin
						o.status = ST_TABLE_FULL;
					end else begin
						entry_position[slot] = o.position;
						case (record_kind)
							KIND_CREATE, KIND_MKDIR: begin
								entry_deleted[slot] = 1'b0;
								entry_size[slot]    = '0;
								entry_mode[slot]    = mode_value;
							end
							KIND_DELETE: begin
								entry_deleted[slot] = 1'b1;
							end
							KIND_TRUNCATE: begin
								entry_deleted[slot] = 1'b0;
								entry_size[slot]    = size_value;
							end
							KIND_WRITE: begin
								// end of the extent saturates, size only grows
								write_end = {1'b0, write_offset} + 65'(write_length);
								if (write_end[64])
									write_end = {1'b0, {64{1'b1}}};
								entry_deleted[slot] = 1'b0;
								if (write_end[63:0] > entry_size[slot])
									entry_size[slot] = write_end[63:0];
							end
							default: begin
								entry_deleted[slot] = 1'b0;
								if (size_valid)
									entry_size[slot] = size_value;
								if (mode_valid)
									entry_mode[slot] = mode_value;
							end
						endcase
					end
				end
			end
		end
		outcome_q.push_back(o);
	endtask

	task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endtask

	// compare results, track capacity writes, predict accepted items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_copy = LOG_CAPACITY_RESET;
			used_copy     = '0;
			foreach (entry_valid[i])
				entry_valid[i] = 1'b0;
			outcome_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (done === 1'b1) begin
				if (outcome_q.size() == 0) begin
					$error("result with no item waiting");
					fail_count++;
				end else begin
					oldest = outcome_q.pop_front();
					check_field("status", 64'(oldest.status), 64'(status));
					check_field("record_position", 64'(oldest.position), 64'(record_position));
					check_field("found", 64'(oldest.found), 64'(found));
					check_field("is_deleted", 64'(oldest.deleted), 64'(is_deleted));
					check_field("inode_size", oldest.size, inode_size);
					check_field("file_mode", 64'(oldest.mode), 64'(file_mode));
				end
			end
			if (cfg_write === 1'b1)
				capacity_copy = cfg_data;
			if (start === 1'b1 && busy === 1'b0)
				predict_index_outcome();
			pending = outcome_q.size();
		end
		log_fill = used_copy;
	end

endmodule

`default_nettype wire

>>> bench/tb_log_append_inode_index_core.sv
`default_nettype none

module tb_log_append_inode_index_core;
	import laii_pkg::*;

	localparam logic [2:0] KIND_UNUSED = 3'd7;
	localparam int GAP_MAX = 18;
	localparam int POOL_SIZE = 128;

	typedef struct {
		cmd_t        command;
		logic [2:0]  kind;
		logic [31:0] ino;
		logic [31:0] new_ino;
		logic [15:0] data;
		logic [31:0] mode;
		logic [63:0] size;
		logic [63:0] offset;
		logic [31:0] length;
		logic        size_ok;
		logic        mode_ok;
	} index_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        command;
	logic [2:0]  record_kind;
	logic [31:0] ino;
	logic [31:0] new_ino;
	logic [15:0] data_bytes;
	logic [31:0] mode_value;
	logic [63:0] size_value;
	logic [63:0] write_offset;
	logic [31:0] write_length;
	logic        size_valid;
	logic        mode_valid;
	logic        cfg_write;
	logic [31:0] cfg_data;
	logic        done;
	logic [1:0]  status;
	logic [31:0] record_position;
	logic        found;
	logic        is_deleted;
	logic [63:0] inode_size;
	logic [31:0] file_mode;
	int          fail_count;
	int          pending;
	logic [31:0] log_fill;

	logic        took = 1'b0;
	bit          no_gaps = 1'b0;
	logic [31:0] inode_pool[POOL_SIZE];
	int          items_sent = 0;
	int          lookups_sent = 0;
	int          cfg_writes = 0;

	log_append_inode_index_core dut (.*);

	inode_index_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// item taken at the last rising edge
	always @(posedge clk)
		took <= start && !busy;

	function automatic index_cmd_t make_cmd(cmd_t cmd, logic [2:0] kind, logic [31:0] key,
			logic [15:0] data, logic [31:0] mode, logic [63:0] size, logic [63:0] offset,
			logic [31:0] length, logic size_ok, logic mode_ok);
		index_cmd_t c;
		c.command = cmd;
		c.kind    = kind;
		c.ino     = key;
		c.new_ino = key;
		c.data    = data;
		c.mode    = mode;
		c.size    = size;
		c.offset  = offset;
		c.length  = length;
		c.size_ok = size_ok;
		c.mode_ok = mode_ok;
		return c;
	endfunction

	// mostly keys from the pool so that entries get revisited
	function automatic logic [31:0] pick_inode(int pool_limit);
		if ($urandom_range(0, 19) == 0)
			return $urandom;
		return inode_pool[$urandom_range(0, pool_limit - 1)];
	endfunction

	function automatic index_cmd_t random_cmd(int pool_limit, bit big_data);
		index_cmd_t c;
		int         r;
		c.command = ($urandom_range(0, 9) < 3) ? CMD_LOOKUP : CMD_APPEND;
		c.kind    = 3'($urandom_range(0, 7));
		c.ino     = pick_inode(pool_limit);
		c.new_ino = pick_inode(pool_limit);
		r = $urandom_range(0, 19);
		if (big_data || r >= 15 && r < 18)
			c.data = 16'($urandom);
		else if (r < 15)
			c.data = 16'($urandom_range(0, 255));
		else
			c.data = (r == 18) ? 16'h0000 : 16'hFFFF;
		c.mode = $urandom;
		r = $urandom_range(0, 9);
		if (r < 5)
			c.size = 64'($urandom_range(0, 1 << 20));
		else if (r < 9)
			c.size = {$urandom, $urandom};
		else
			c.size = '1;
		r = $urandom_range(0, 9);
		c.offset = (r < 8) ? 64'($urandom_range(0, 1 << 20)) : {$urandom, $urandom};
		c.length = (r < 5) ? 32'($urandom_range(0, 65535)) : $urandom;
		c.size_ok = 1'($urandom_range(0, 1));
		c.mode_ok = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// present one item after a random gap and hold it until taken
	task automatic send_item(input index_cmd_t c);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		command      <= c.command;
		record_kind  <= c.kind;
		ino          <= c.ino;
		new_ino      <= c.new_ino;
		data_bytes   <= c.data;
		mode_value   <= c.mode;
		size_value   <= c.size;
		write_offset <= c.offset;
		write_length <= c.length;
		size_valid   <= c.size_ok;
		mode_valid   <= c.mode_ok;
		start        <= 1'b1;
		items_sent++;
		if (c.command == CMD_LOOKUP)
			lookups_sent++;
		@(negedge clk);
		while (!took)
			@(negedge clk);
	endtask

	// capacity is only changed once every result is back
	task automatic set_capacity(input logic [31:0] value);
		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_write <= 1'b1;
		cfg_data  <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
		cfg_writes++;
	endtask

	task automatic random_phase(input int count, input int pool_limit, input bit big_data);
		for (int n = 0; n < count; n++) begin
			// occasional runs of back-to-back items
			if (n % 40 == 0)
				no_gaps = ($urandom_range(0, 3) == 0);
			send_item(random_cmd(pool_limit, big_data));
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		start        = 1'b0;
		command      = CMD_APPEND;
		record_kind  = KIND_CREATE;
		ino          = '0;
		new_ino      = '0;
		data_bytes   = '0;
		mode_value   = '0;
		size_value   = '0;
		write_offset = '0;
		write_length = '0;
		size_valid   = 1'b0;
		mode_valid   = 1'b0;
		cfg_write    = 1'b0;
		cfg_data     = '0;
		arst_n       = 1'b0;
		inode_pool[0] = '0;
		inode_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			inode_pool[i] = $urandom;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: miss, extreme keys and payloads, every kind, saturation, deletion
		send_item(make_cmd(CMD_LOOKUP, KIND_CREATE, 32'd5, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_CREATE, 32'h0, 16'h0, '1, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_MKDIR, '1, 16'hFFFF, 32'h41ED, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_LOOKUP, KIND_CREATE, 32'h0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_LOOKUP, KIND_CREATE, '1, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_WRITE, 32'h0, 16'd100, 0, 0,
			64'hFFFF_FFFF_FFFF_FFF0, 32'd100, 0, 0));
		send_item(make_cmd(CMD_LOOKUP, KIND_CREATE, 32'h0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_WRITE, 32'h0, 16'd7, 0, 0, 0, 32'd10, 0, 0));
		send_item(make_cmd(CMD_LOOKUP, KIND_CREATE, 32'h0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_TRUNCATE, 32'h0, 16'd1, 0, 64'd0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_TRUNCATE, '1, 16'd2, 0, '1, 0, 0, 0, 0));
		send_item(make_cmd(CMD_LOOKUP, KIND_CREATE, '1, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_SETATTR, 32'h0, 16'd3, 32'h1A4, 64'd77, 0, 0,
			1, 0));
		send_item(make_cmd(CMD_APPEND, KIND_SETATTR, 32'h0, 16'd4, 32'h1A4, 64'd88, 0, 0,
			0, 1));
		send_item(make_cmd(CMD_APPEND, KIND_SETATTR, 32'h0, 16'd5, 32'h1FF, 64'd99, 0, 0,
			0, 0));
		send_item(make_cmd(CMD_LOOKUP, KIND_CREATE, 32'h0, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_SETATTR, 32'h0, 16'd6, '1, '1, 0, 0, 1, 1));
		send_item(make_cmd(CMD_APPEND, KIND_DELETE, '1, 16'd8, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_LOOKUP, KIND_CREATE, '1, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_WRITE, 32'd7, 16'd9, 0, 0, 64'd50, '1, 0, 0));
		send_item(make_cmd(CMD_LOOKUP, KIND_CREATE, 32'd7, 0, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_RENAME, 32'h0, 16'd10, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_UNUSED, 32'h0, 16'd11, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_LOOKUP, KIND_CREATE, 32'h0, 0, 0, 0, 0, 0, 0, 0));

		// no room at all: every append refused
		set_capacity(32'h0);
		send_item(make_cmd(CMD_APPEND, KIND_CREATE, 32'd9, 16'h0, 0, 0, 0, 0, 0, 0));
		send_item(make_cmd(CMD_APPEND, KIND_WRITE, 32'h0, 16'hFFFF, 0, 0, 0, 1, 0, 0));
		send_item(make_cmd(CMD_LOOKUP, KIND_CREATE, 32'd9, 0, 0, 0, 0, 0, 0, 0));

		// wide open log, keys from a pool that fits the table
		set_capacity('1);
		random_phase(280, 40, 1'b0);

		// log close to its limit with large payloads
		set_capacity(log_fill + 32'($urandom_range(0, 300000)));
		random_phase(60, 40, 1'b1);

		// more keys than entries so the table fills up
		set_capacity('1);
		random_phase(160, POOL_SIZE, 1'b0);

		// back to the reset capacity, likely below the fill by now
		set_capacity(LOG_CAPACITY_RESET);
		random_phase(12, POOL_SIZE, 1'b0);

		start <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (80) @(negedge clk);

		$display("covered %0d items (%0d lookups) under %0d capacity settings",
			items_sent, lookups_sent, cfg_writes);
		if (fail_count == 0 && pending == 0)
			$display("tb_log_append_inode_index_core OK");
		else
			$display("tb_log_append_inode_index_core NOT OK");
		$finish;
	end

	// overall time limit
	initial begin
		#5000000;
		$display("tb_log_append_inode_index_core NOT OK");
		$finish;
	end

endmodule

`default_nettype wire

>>> filelist.f
hdl/laii_pkg.sv
hdl/laii_ram.sv
hdl/log_append_inode_index_core.sv
hdl/laii_checker.sv
bench/inode_index_checker.sv
bench/tb_log_append_inode_index_core.sv
